// ----- design/tts_pkg.sv -----
`default_nettype none
package tts_pkg;

    // Magnitudes are brought below this power of two before squaring.
    localparam int MAG_BITS = 30;

    // Flags that travel with every item down the pipeline.
    typedef struct packed {
        logic valid;
        logic skipped;
        logic degenerate;
        logic last;
    } tts_tag_t;

    // Per-vector control for the normalising unit.
    typedef struct packed {
        logic kill;
        logic flip;
    } tts_ctl_t;

endpackage
`default_nettype wire

// ----- design/tts_tri_if.sv -----
`default_nettype none
interface tts_tri_if #(
    parameter int CW  = 20,
    parameter int UVW = 16
);
    logic              valid;
    logic              ready;
    logic [3*CW-1:0]   first_position;
    logic [3*CW-1:0]   second_position;
    logic [3*CW-1:0]   third_position;
    logic [2*UVW-1:0]  first_uv;
    logic [2*UVW-1:0]  second_uv;
    logic [2*UVW-1:0]  third_uv;
    logic              any_modified;
    logic              last_triangle;

    modport source (
        output valid, first_position, second_position, third_position,
               first_uv, second_uv, third_uv, any_modified, last_triangle,
        input  ready
    );
    modport sink (
        input  valid, first_position, second_position, third_position,
               first_uv, second_uv, third_uv, any_modified, last_triangle,
        output ready
    );
endinterface
`default_nettype wire

// ----- design/tts_res_if.sv -----
`default_nettype none
interface tts_res_if #(
    parameter int VW = 16
);
    logic            valid;
    logic            ready;
    logic [3*VW-1:0] unit_normal;
    logic [3*VW-1:0] unit_tangent;
    logic [3*VW-1:0] unit_bitangent;
    logic            skipped;
    logic            degenerate;
    logic            last_result;

    modport source (
        output valid, unit_normal, unit_tangent, unit_bitangent,
               skipped, degenerate, last_result,
        input  ready
    );
    modport sink (
        input  valid, unit_normal, unit_tangent, unit_bitangent,
               skipped, degenerate, last_result,
        output ready
    );
endinterface
`default_nettype wire

// ----- design/tts_normalize.sv -----
`default_nettype none
module tts_normalize
    import tts_pkg::*;
#(
    parameter int IW = 43,
    parameter int VW = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic signed [IW-1:0] c [3],
    input  wire tts_ctl_t             ctl,
    input  wire tts_tag_t             tag_in,
    output logic [3*VW-1:0]           vec,
    output tts_tag_t                  tag_out
);

    localparam int MB   = MAG_BITS;
    localparam int SW   = (IW < MB) ? IW : MB;
    localparam int NS   = (IW > MB) ? $clog2(IW - MB + 1) : 0;
    localparam int SUMW = 2 * SW + 2;
    localparam int SQ   = SW + 1;
    localparam int QW   = VW - 1;
    localparam int RW   = SW + VW;

    typedef struct packed {
        logic [2:0][SW-1:0] mag;
        logic [2:0]         neg;
        logic               zero;
    } side_t;

    // Absolute value and largest magnitude.
    logic [IW-1:0] sh_mag_reg [NS+1][3];
    logic [IW-1:0] sh_max_reg [NS+1];
    logic [2:0]    sh_neg_reg [NS+1];
    logic          sh_zero_reg [NS+1];
    tts_tag_t      sh_tag_reg [NS+1];

    logic [IW-1:0] a_mag_next [3];
    logic [IW-1:0] a_max_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_mag_next[i] = c[i][IW-1] ? IW'(-c[i]) : IW'(c[i]);
        end
        a_max_next = a_mag_next[0];
        if (a_mag_next[1] > a_max_next)
        begin
            a_max_next = a_mag_next[1];
        end
        if (a_mag_next[2] > a_max_next)
        begin
            a_max_next = a_mag_next[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sh_mag_reg[0][i] <= a_mag_next[i];
                sh_neg_reg[0][i] <= c[i][IW-1] ^ ctl.flip;
            end
            sh_max_reg[0]  <= a_max_next;
            sh_zero_reg[0] <= (a_max_next == '0) || ctl.kill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_tag_reg[0] <= '0;
        end
        else if (en)
        begin
            sh_tag_reg[0] <= tag_in;
        end
    end

    // Binary shift search: each step removes one power of two of the excess.
    for (genvar s = 0; s < NS; s++)
    begin : g_shift
        localparam int K = 1 << (NS - 1 - s);
        logic do_shift;
        assign do_shift = (sh_max_reg[s] >> (MB - 1 + K)) != '0;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sh_mag_reg[s+1][i] <= do_shift ? (sh_mag_reg[s][i] >> K)
                                                   : sh_mag_reg[s][i];
                end
                sh_max_reg[s+1]  <= do_shift ? (sh_max_reg[s] >> K) : sh_max_reg[s];
                sh_neg_reg[s+1]  <= sh_neg_reg[s];
                sh_zero_reg[s+1] <= sh_zero_reg[s];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sh_tag_reg[s+1] <= '0;
            end
            else if (en)
            begin
                sh_tag_reg[s+1] <= sh_tag_reg[s];
            end
        end
    end

    // Squares, then their sum.
    logic [2*SW-1:0] sq_reg [3];
    side_t           sq_side_reg;
    tts_tag_t        sq_tag_reg;
    side_t           sq_side_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_side_next.mag[i] = SW'(sh_mag_reg[NS][i]);
        end
        sq_side_next.neg  = sh_neg_reg[NS];
        sq_side_next.zero = sh_zero_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= sq_side_next.mag[i] * sq_side_next.mag[i];
            end
            sq_side_reg <= sq_side_next;
        end
    end

    // Square root, two radicand bits per stage.
    logic [SUMW-1:0] rt_x_reg    [SQ+1];
    logic [SQ+1:0]   rt_rem_reg  [SQ+1];
    logic [SQ-1:0]   rt_root_reg [SQ+1];
    side_t           rt_side_reg [SQ+1];
    tts_tag_t        rt_tag_reg  [SQ+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_x_reg[0]    <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
            rt_rem_reg[0]  <= '0;
            rt_root_reg[0] <= '0;
            rt_side_reg[0] <= sq_side_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_tag_reg    <= '0;
            rt_tag_reg[0] <= '0;
        end
        else if (en)
        begin
            sq_tag_reg    <= sh_tag_reg[NS];
            rt_tag_reg[0] <= sq_tag_reg;
        end
    end

    for (genvar j = 0; j < SQ; j++)
    begin : g_sqrt
        logic [SQ+1:0] rem_sh;
        logic [SQ+1:0] trial;
        logic          take;

        always_comb
        begin
            rem_sh = {rt_rem_reg[j][SQ-1:0], rt_x_reg[j][SUMW-1 -: 2]};
            trial  = {rt_root_reg[j], 2'b01};
            take   = rem_sh >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_x_reg[j+1]    <= rt_x_reg[j] << 2;
                rt_rem_reg[j+1]  <= take ? (rem_sh - trial) : rem_sh;
                rt_root_reg[j+1] <= {rt_root_reg[j][SQ-2:0], take};
                rt_side_reg[j+1] <= rt_side_reg[j];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_tag_reg[j+1] <= '0;
            end
            else if (en)
            begin
                rt_tag_reg[j+1] <= rt_tag_reg[j];
            end
        end
    end

    // Restoring division of the rounded, scaled magnitude by the root.
    logic [RW-1:0] dv_rem_reg  [QW+1][3];
    logic [QW-1:0] dv_q_reg    [QW+1][3];
    logic [SQ-1:0] dv_div_reg  [QW+1];
    side_t         dv_side_reg [QW+1];
    tts_tag_t      dv_tag_reg  [QW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= (RW'(rt_side_reg[SQ].mag[i]) << (VW - 2))
                                    + RW'(rt_root_reg[SQ] >> 1);
                dv_q_reg[0][i]   <= '0;
            end
            dv_div_reg[0]  <= rt_root_reg[SQ];
            dv_side_reg[0] <= rt_side_reg[SQ];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_tag_reg[0] <= '0;
        end
        else if (en)
        begin
            dv_tag_reg[0] <= rt_tag_reg[SQ];
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_div
        localparam int B = QW - 1 - s;
        logic [RW-1:0] shifted;
        assign shifted = RW'(dv_div_reg[s]) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (dv_rem_reg[s][i] >= shifted)
                    begin
                        dv_rem_reg[s+1][i]  <= dv_rem_reg[s][i] - shifted;
                        dv_q_reg[s+1][i]    <= dv_q_reg[s][i] | (QW'(1) << B);
                    end
                    else
                    begin
                        dv_rem_reg[s+1][i]  <= dv_rem_reg[s][i];
                        dv_q_reg[s+1][i]    <= dv_q_reg[s][i];
                    end
                end
                dv_div_reg[s+1]  <= dv_div_reg[s];
                dv_side_reg[s+1] <= dv_side_reg[s];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_tag_reg[s+1] <= '0;
            end
            else if (en)
            begin
                dv_tag_reg[s+1] <= dv_tag_reg[s];
            end
        end
    end

    // Sign, zero masking and packing. The quotient never exceeds the
    // largest positive code, so no saturation logic is needed.
    logic [3*VW-1:0] vec_reg;
    logic [3*VW-1:0] vec_next;
    tts_tag_t        tag_out_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_side_reg[QW].zero)
            begin
                vec_next[i*VW +: VW] = '0;
            end
            else if (dv_side_reg[QW].neg[i])
            begin
                vec_next[i*VW +: VW] = -{1'b0, dv_q_reg[QW][i]};
            end
            else
            begin
                vec_next[i*VW +: VW] = {1'b0, dv_q_reg[QW][i]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_out_reg <= '0;
        end
        else if (en)
        begin
            tag_out_reg <= dv_tag_reg[QW];
        end
    end

    assign vec     = vec_reg;
    assign tag_out = tag_out_reg;

endmodule
`default_nettype wire

// ----- design/triangle_tangent_space.sv -----
// Triangle tangent-space unit.
// The triangle channel takes one gathered triangle per item: three packed
// vertex positions, three packed UV pairs, a modified flag and an end mark.
// The result channel returns one item per triangle, in order: the unit normal
// of the triangle, the shared unit tangent and bitangent, and the
// skipped, degenerate and end flags.
// The pipeline runs through the edge-difference, product and difference
// stages, then per normalising unit the absolute value, the NS shift-search
// steps, the squares, their sum, the square-root stages, the division setup,
// the division stages and the output register. The square root takes one
// result bit per stage, the division one quotient bit: these set the depth.
// Throughput is one triangle per cycle while the receiver does not stall:
// every stage is registered and nothing is shared between items.
// Reset clears all valid bits; no result is presented afterwards until a
// triangle has passed through. When the receiver stalls, the whole pipeline
// holds and the triangle channel deasserts ready; a bubble in the input
// stream travels as an empty slot.
`default_nettype none
module triangle_tangent_space
    import tts_pkg::*;
#(
    parameter int COORD_WIDTH  = 20,
    parameter int UV_WIDTH     = 16,
    parameter int VECTOR_WIDTH = 16
) (
    input wire logic  clk,
    input wire logic  rst_n,
    tts_tri_if.sink   triangle,
    tts_res_if.source result
);

    localparam int CW  = COORD_WIDTH;
    localparam int UVW = UV_WIDTH;
    localparam int VW  = VECTOR_WIDTH;
    localparam int DW  = CW + 1;
    localparam int UD  = UVW + 1;
    localparam int VIN = DW + ((DW > UD) ? DW : UD) + 1;
    localparam int PW  = UD + DW;
    localparam int TW  = 2 * UD;

    logic en;
    assign en             = !result.valid || result.ready;
    assign triangle.ready = en;

    // Stage 1: edge and UV differences.
    logic signed [DW-1:0] a_reg [3];
    logic signed [DW-1:0] b_reg [3];
    logic signed [UD-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    tts_tag_t             s1_tag_reg;

    logic signed [CW-1:0] p1 [3];
    logic signed [CW-1:0] p2 [3];
    logic signed [CW-1:0] p3 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p1[i] = triangle.first_position[i*CW +: CW];
            p2[i] = triangle.second_position[i*CW +: CW];
            p3[i] = triangle.third_position[i*CW +: CW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i] <= DW'(p1[i]) - DW'(p2[i]);
                b_reg[i] <= DW'(p1[i]) - DW'(p3[i]);
            end
            du1_reg <= $signed({1'b0, triangle.second_uv[UVW-1:0]})
                     - $signed({1'b0, triangle.first_uv[UVW-1:0]});
            dv1_reg <= $signed({1'b0, triangle.second_uv[2*UVW-1:UVW]})
                     - $signed({1'b0, triangle.first_uv[2*UVW-1:UVW]});
            du2_reg <= $signed({1'b0, triangle.third_uv[UVW-1:0]})
                     - $signed({1'b0, triangle.first_uv[UVW-1:0]});
            dv2_reg <= $signed({1'b0, triangle.third_uv[2*UVW-1:UVW]})
                     - $signed({1'b0, triangle.first_uv[2*UVW-1:UVW]});
        end
    end

    // Stage 2: products. With e1 = -a and e2 = -b the tangent is
    // dv1*b - dv2*a and the bitangent du2*a - du1*b.
    logic signed [2*DW-1:0] nl_reg [3];
    logic signed [2*DW-1:0] nr_reg [3];
    logic signed [PW-1:0]   tl_reg [3];
    logic signed [PW-1:0]   tr_reg [3];
    logic signed [PW-1:0]   bl_reg [3];
    logic signed [PW-1:0]   br_reg [3];
    logic signed [TW-1:0]   dl_reg, dr_reg;
    tts_tag_t               s2_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nl_reg[0] <= a_reg[1] * b_reg[2];
            nr_reg[0] <= a_reg[2] * b_reg[1];
            nl_reg[1] <= a_reg[2] * b_reg[0];
            nr_reg[1] <= a_reg[0] * b_reg[2];
            nl_reg[2] <= a_reg[0] * b_reg[1];
            nr_reg[2] <= a_reg[1] * b_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                tl_reg[i] <= dv1_reg * b_reg[i];
                tr_reg[i] <= dv2_reg * a_reg[i];
                bl_reg[i] <= du2_reg * a_reg[i];
                br_reg[i] <= du1_reg * b_reg[i];
            end
            dl_reg <= du1_reg * dv2_reg;
            dr_reg <= du2_reg * dv1_reg;
        end
    end

    // Stage 3: differences and the sign of the UV determinant.
    logic signed [VIN-1:0] n_reg [3];
    logic signed [VIN-1:0] t_reg [3];
    logic signed [VIN-1:0] bt_reg [3];
    tts_ctl_t              n_ctl_reg, t_ctl_reg;
    tts_tag_t              s3_tag_reg;

    logic signed [TW:0] det;
    logic               det_zero;
    assign det      = (TW+1)'(dl_reg) - (TW+1)'(dr_reg);
    assign det_zero = det == '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i]  <= VIN'(nl_reg[i]) - VIN'(nr_reg[i]);
                t_reg[i]  <= VIN'(tl_reg[i]) - VIN'(tr_reg[i]);
                bt_reg[i] <= VIN'(bl_reg[i]) - VIN'(br_reg[i]);
            end
            n_ctl_reg.kill <= s2_tag_reg.skipped;
            n_ctl_reg.flip <= 1'b0;
            t_ctl_reg.kill <= s2_tag_reg.skipped || det_zero;
            t_ctl_reg.flip <= det[TW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else if (en)
        begin
            s1_tag_reg.valid      <= triangle.valid;
            s1_tag_reg.skipped    <= !triangle.any_modified;
            s1_tag_reg.degenerate <= 1'b0;
            s1_tag_reg.last       <= triangle.last_triangle;
            s2_tag_reg            <= s1_tag_reg;
            s3_tag_reg            <= {s2_tag_reg.valid, s2_tag_reg.skipped,
                                      !s2_tag_reg.skipped && det_zero, s2_tag_reg.last};
        end
    end

    tts_tag_t tag_out;
    tts_tag_t no_tag;
    assign no_tag = '0;

    tts_normalize #(.IW(VIN), .VW(VW)) u_norm_n (
        .clk(clk), .rst_n(rst_n), .en(en), .c(n_reg), .ctl(n_ctl_reg),
        .tag_in(s3_tag_reg), .vec(result.unit_normal), .tag_out(tag_out)
    );

    tts_normalize #(.IW(VIN), .VW(VW)) u_norm_t (
        .clk(clk), .rst_n(rst_n), .en(en), .c(t_reg), .ctl(t_ctl_reg),
        .tag_in(no_tag), .vec(result.unit_tangent), .tag_out()
    );

    tts_normalize #(.IW(VIN), .VW(VW)) u_norm_b (
        .clk(clk), .rst_n(rst_n), .en(en), .c(bt_reg), .ctl(t_ctl_reg),
        .tag_in(no_tag), .vec(result.unit_bitangent), .tag_out()
    );

    assign result.valid       = tag_out.valid;
    assign result.skipped     = tag_out.skipped;
    assign result.degenerate  = tag_out.degenerate;
    assign result.last_result = tag_out.last;

`ifndef SYNTHESIS
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.skipped |-> result.unit_normal == '0
            && result.unit_tangent == '0 && result.unit_bitangent == '0
            && !result.degenerate)
        else $error("skipped item carries non-zero vectors");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.degenerate |-> result.unit_tangent == '0
            && result.unit_bitangent == '0)
        else $error("degenerate item carries a tangent");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        triangle.ready == (!result.valid || result.ready))
        else $error("input ready does not follow the output stall");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid
            && $stable(result.unit_normal) && $stable(result.last_result))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ----- tb/triangle_tangent_space_tb.sv -----
`default_nettype none
class tangent_scoreboard;
    typedef struct {
        logic [47:0] normal;
        logic [47:0] tangent;
        logic [47:0] bitangent;
        logic        skipped;
        logic        degenerate;
        logic        last;
    } frame_t;

    frame_t pending_frames[$];
    int     mismatches;

    function new();
        mismatches = 0;
    endfunction

    static function logic [47:0] to_unit(longint c[3]);
        longint unsigned mag[3];
        longint unsigned m;
        longint unsigned sum;
        longint unsigned r;
        longint unsigned q;
        longint unsigned x;
        longint unsigned b;
        logic [47:0] packed_vec;
        m = 0;
        sum = 0;
        packed_vec = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = c[i] < 0 ? -c[i] : c[i];
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
            return '0;
        while (m >= (64'd1 << 30))
        begin
            m = m >> 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
        end
        for (int i = 0; i < 3; i++)
            sum += mag[i] * mag[i];
        // Bitwise integer square root, truncating.
        x = sum;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << 14) + (r >> 1)) / r;
            if (q > 32767)
                q = 32767;
            if (c[i] < 0)
                q = -q;
            packed_vec[16*i +: 16] = q[15:0];
        end
        return packed_vec;
    endfunction

    function void note_triangle(logic [59:0] p1w, logic [59:0] p2w, logic [59:0] p3w,
                                logic [31:0] t1w, logic [31:0] t2w, logic [31:0] t3w,
                                logic modified, logic last);
        frame_t f;
        longint p1[3];
        longint p2[3];
        longint p3[3];
        longint a[3];
        longint bb[3];
        longint e1[3];
        longint e2[3];
        longint n[3];
        longint tg[3];
        longint bt[3];
        longint du1;
        longint dv1;
        longint du2;
        longint dv2;
        longint det;
        f.normal = '0;
        f.tangent = '0;
        f.bitangent = '0;
        f.skipped = 0;
        f.degenerate = 0;
        f.last = last;
        if (!modified)
        begin
            f.skipped = 1;
            pending_frames = {pending_frames, f};
            return;
        end
        for (int i = 0; i < 3; i++)
        begin
            p1[i] = longint'($signed(p1w[20*i +: 20]));
            p2[i] = longint'($signed(p2w[20*i +: 20]));
            p3[i] = longint'($signed(p3w[20*i +: 20]));
            a[i] = p1[i] - p2[i];
            bb[i] = p1[i] - p3[i];
            e1[i] = -a[i];
            e2[i] = -bb[i];
        end
        n[0] = a[1] * bb[2] - a[2] * bb[1];
        n[1] = a[2] * bb[0] - a[0] * bb[2];
        n[2] = a[0] * bb[1] - a[1] * bb[0];
        f.normal = to_unit(n);
        du1 = longint'(t2w[15:0]) - longint'(t1w[15:0]);
        dv1 = longint'(t2w[31:16]) - longint'(t1w[31:16]);
        du2 = longint'(t3w[15:0]) - longint'(t1w[15:0]);
        dv2 = longint'(t3w[31:16]) - longint'(t1w[31:16]);
        det = du1 * dv2 - du2 * dv1;
        if (det == 0)
            f.degenerate = 1;
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                tg[i] = dv2 * e1[i] - dv1 * e2[i];
                bt[i] = du1 * e2[i] - du2 * e1[i];
                if (det < 0)
                begin
                    tg[i] = -tg[i];
                    bt[i] = -bt[i];
                end
            end
            f.tangent = to_unit(tg);
            f.bitangent = to_unit(bt);
        end
        pending_frames = {pending_frames, f};
    endfunction

    function void check_result(logic [47:0] normal, logic [47:0] tangent,
                               logic [47:0] bitangent, logic skipped,
                               logic degenerate, logic last);
        frame_t f;
        if (pending_frames.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result item: normal %h", normal);
            return;
        end
        f = pending_frames.pop_front();
        if (f.normal !== normal || f.tangent !== tangent || f.bitangent !== bitangent
            || f.skipped !== skipped || f.degenerate !== degenerate || f.last !== last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected n %h t %h b %h s%b d%b l%b,",
                         f.normal, f.tangent, f.bitangent, f.skipped, f.degenerate,
                         f.last, " got n %h t %h b %h s%b d%b l%b",
                         normal, tangent, bitangent, skipped, degenerate, last);
        end
    endfunction
endclass

module triangle_tangent_space_tb;
    import tts_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY = 58;

    logic clk = 0;
    logic rst_n = 0;
    int   idle_cycles = 0;

    tts_tri_if #(.CW(20), .UVW(16)) triangle ();
    tts_res_if #(.VW(16)) result ();

    triangle_tangent_space u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .triangle (triangle.sink),
        .result   (result.source)
    );

    tangent_scoreboard board = new();

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (triangle.valid && triangle.ready)
                board.note_triangle(triangle.first_position, triangle.second_position,
                                    triangle.third_position, triangle.first_uv,
                                    triangle.second_uv, triangle.third_uv,
                                    triangle.any_modified, triangle.last_triangle);
            if (result.valid && result.ready)
                board.check_result(result.unit_normal, result.unit_tangent,
                                   result.unit_bitangent, result.skipped,
                                   result.degenerate, result.last_result);
            if ((triangle.valid && triangle.ready) || (result.valid && result.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, including bursts with none.
    initial
    begin
        int gap;
        result.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = gap_length();
            if (gap == 0)
                result.ready <= 1;
            else
            begin
                result.ready <= 0;
                repeat (gap) @(negedge clk);
                result.ready <= 1;
            end
        end
    end

    task automatic send_triangle(logic [59:0] p1, logic [59:0] p2, logic [59:0] p3,
                                 logic [31:0] t1, logic [31:0] t2, logic [31:0] t3,
                                 logic modified, logic last, bit allow_gap);
        int gap;
        gap = allow_gap ? gap_length() : 0;
        if (gap > 0)
        begin
            triangle.valid <= 0;
            repeat (gap) @(negedge clk);
        end
        triangle.valid <= 1;
        triangle.first_position <= p1;
        triangle.second_position <= p2;
        triangle.third_position <= p3;
        triangle.first_uv <= t1;
        triangle.second_uv <= t2;
        triangle.third_uv <= t3;
        triangle.any_modified <= modified;
        triangle.last_triangle <= last;
        @(posedge clk);
        while (!triangle.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [59:0] random_position(int span);
        logic [59:0] p;
        for (int i = 0; i < 3; i++)
        begin
            if (span >= 20)
                p[20*i +: 20] = 20'($urandom());
            else
                p[20*i +: 20] = 20'($signed($urandom_range(0, 2 ** span)) - (2 ** (span - 1)));
        end
        return p;
    endfunction

    initial
    begin
        logic [59:0] q1;
        logic [59:0] q2;
        logic [59:0] q3;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        int span;
        bit bursty;
        triangle.valid = 0;
        triangle.first_position = '0;
        triangle.second_position = '0;
        triangle.third_position = '0;
        triangle.first_uv = '0;
        triangle.second_uv = '0;
        triangle.third_uv = '0;
        triangle.any_modified = 0;
        triangle.last_triangle = 0;
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: skipped, zero length, zero determinant, extreme coordinates.
        send_triangle('0, '0, '0, '0, '0, '0, 0, 0, 0);
        send_triangle('1, 60'h12345, '0, '1, '0, 32'h1234, 0, 1, 0);
        send_triangle('0, '0, '0, 32'h0001_0000, 32'h0000_0001, 32'h0001_0001, 1, 0, 0);
        send_triangle(60'h0, 60'h00000_00000_7FFFF, 60'h00000_7FFFF_00000,
                      32'h0, 32'h0000_FFFF, 32'hFFFF_0000, 1, 0, 0);
        send_triangle({20'h7FFFF, 20'h80000, 20'h7FFFF}, {20'h80000, 20'h7FFFF, 20'h80000},
                      {20'h80000, 20'h80000, 20'h7FFFF}, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_0000,
                      1, 1, 0);
        send_triangle({20'h80000, 20'h80000, 20'h80000}, {20'h7FFFF, 20'h7FFFF, 20'h7FFFF},
                      {20'h7FFFF, 20'h80000, 20'h00000}, 32'h0, 32'hFFFF_FFFF, 32'h0000_FFFF,
                      1, 0, 0);
        send_triangle(60'h0, 60'h00000_00000_00100, 60'h00000_00100_00000,
                      32'h0, 32'h0000_0100, 32'h0100_0000, 1, 0, 0);
        send_triangle(60'h0, 60'h00000_00000_00100, 60'h00000_00100_00000,
                      32'h0, 32'h0100_0000, 32'h0000_0100, 1, 1, 0);
        // Collinear points give a zero normal but may still have a tangent.
        send_triangle(60'h0, 60'h00000_00000_00001, 60'h00000_00000_00002,
                      32'h0, 32'h0000_0010, 32'h0010_0000, 1, 0, 0);
        send_triangle(60'h0, 60'h00000_00000_00001, 60'h00000_00001_00000,
                      32'h0, 32'h0000_0001, 32'h0000_0002, 1, 0, 0);
        send_triangle(60'h0, 60'h00000_00000_00001, 60'h00000_00001_00000,
                      32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_0000, 1, 0, 0);

        for (int k = 0; k < 1250; k++)
        begin
            bursty = (k % 200) < 30;
            span = $urandom_range(0, 3) == 0 ? 20 : $urandom_range(2, 19);
            q1 = random_position(span);
            q2 = random_position(span);
            q3 = random_position(span);
            w1 = $urandom();
            w2 = $urandom();
            w3 = $urandom();
            case ($urandom_range(0, 9))
                0: w3 = w2;
                1: q3 = q2;
                2:
                begin
                    w2 = w1;
                    w3 = {w1[31:16] + 16'd3, w1[15:0]};
                end
                3: w1 = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                default: ;
            endcase
            send_triangle(q1, q2, q3, w1, w2, w3, $urandom_range(0, 7) != 0,
                          1'($urandom_range(0, 1)), !bursty);
        end
        triangle.valid <= 0;

        while (board.pending_frames.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
